FILE: rtl/core/bcts_pkg.sv
// shared types, constants and codes for the battery capacity test sequencer
package bcts_pkg;

    // default number of test channels
    localparam int NUM_CHANNELS_DEF = 4;

    // fixed field widths
    localparam int CH_FIELD_W  = 2;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    // input queue between the front and the back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // capacity conversion from mA-s to mAh
    localparam int SECONDS_PER_HOUR = 3600;
    localparam int RECIP_SHIFT      = 32;
    localparam longint unsigned RECIP_VAL = (64'd1 << RECIP_SHIFT) / SECONDS_PER_HOUR;
    localparam int RECIP_W          = 21;
    localparam int QUOT_W           = 21;
    localparam int PROD_W           = 32 + RECIP_W;

    // drive current once fully recharged
    localparam logic signed [15:0] TRICKLE_MA = 16'sd10;

    // register reset values
    localparam logic [15:0] RST_FULL_V    = 16'd1700;
    localparam logic [15:0] RST_PEAK_DROP = 16'd10;
    localparam logic [15:0] RST_FAULT_V   = 16'd500;
    localparam logic [15:0] RST_ABSENT_V  = 16'd1800;
    localparam logic [15:0] RST_IDLE_CUR  = 16'd10;
    localparam logic [15:0] RST_EMPTY_V   = 16'd1000;
    localparam logic [14:0] RST_CHG_CUR   = 15'd400;
    localparam logic [14:0] RST_DIS_CUR   = 15'd400;

    typedef enum logic [3:0] {
        PH_ERROR     = 4'd0,
        PH_ABSENT    = 4'd1,
        PH_SETUP     = 4'd2,
        PH_CHARGE    = 4'd3,
        PH_WAIT1     = 4'd4,
        PH_DISCHARGE = 4'd5,
        PH_WAIT2     = 4'd6,
        PH_RECHARGE  = 4'd7,
        PH_CHARGED   = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        CFG_FULL_V    = 3'd0,
        CFG_PEAK_DROP = 3'd1,
        CFG_FAULT_V   = 3'd2,
        CFG_ABSENT_V  = 3'd3,
        CFG_IDLE_CUR  = 3'd4,
        CFG_EMPTY_V   = 3'd5,
        CFG_CHG_CUR   = 3'd6,
        CFG_DIS_CUR   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0]        full_v;
        logic [15:0]        peak_drop;
        logic [15:0]        fault_v;
        logic [15:0]        absent_v;
        logic signed [15:0] idle_cur;
        logic [15:0]        empty_v;
        logic [14:0]        chg_cur;
        logic [14:0]        dis_cur;
    } cfg_t;

    typedef struct packed {
        logic [CH_FIELD_W-1:0] channel;
        logic [15:0]           voltage;
        logic signed [15:0]    current;
        logic signed [15:0]    avg_current;
        logic                  start;
        logic                  fault;
    } item_t;

    typedef struct packed {
        logic [CH_FIELD_W-1:0] channel;
        phase_t                phase;
        logic signed [15:0]    drive;
        logic signed [31:0]    cap;
        logic                  div_pending;
        logic                  wiring;
    } res_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

endpackage

FILE: rtl/core/bcts_front.sv
// front part: item acceptance, channel range check and input queue
module bcts_front #(
    parameter int NUM_CHANNELS = bcts_pkg::NUM_CHANNELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bcts_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic [bcts_pkg::CH_FIELD_W-1:0]   s_axis_tuser,
    input  logic                              pop,
    output bcts_pkg::q_head_t                 head
);

    localparam logic [4:0] NCH = 5'(NUM_CHANNELS);

    bcts_pkg::item_t               q_mem_reg [bcts_pkg::QDEPTH];
    logic [bcts_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [bcts_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [bcts_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [bcts_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [bcts_pkg::QPTR_W:0]     count_reg;
    logic [bcts_pkg::QPTR_W:0]     count_next;
    logic                          in_range;
    logic                          push;
    bcts_pkg::item_t               in_item;

    assign in_item.channel     = s_axis_tuser;
    assign in_item.voltage     = s_axis_tdata[15:0];
    assign in_item.current     = $signed(s_axis_tdata[31:16]);
    assign in_item.avg_current = $signed(s_axis_tdata[47:32]);
    assign in_item.start       = s_axis_tdata[48];
    assign in_item.fault       = s_axis_tdata[49];

    // items for channels that do not exist are taken and dropped
    assign in_range      = {3'b000, s_axis_tuser} < NCH;
    assign s_axis_tready = count_reg != (bcts_pkg::QPTR_W + 1)'(bcts_pkg::QDEPTH);
    assign push          = s_axis_tvalid && s_axis_tready && in_range;

    assign head.valid = count_reg != '0;
    assign head.item  = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (bcts_pkg::QPTR_W + 1)'(push)
                      - (bcts_pkg::QPTR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: rtl/core/bcts_exec.sv
// back part: per-channel phase sequencing and capacity integration
module bcts_exec #(
    parameter int NUM_CHANNELS = bcts_pkg::NUM_CHANNELS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bcts_pkg::cfg_t       cfg,
    input  bcts_pkg::q_head_t    head,
    input  logic                 advance,
    output logic                 pop,
    output logic                 a_valid,
    output bcts_pkg::res_t       a_res
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    bcts_pkg::phase_t       phase_reg [NUM_CHANNELS];
    logic [15:0]            peak_reg  [NUM_CHANNELS];
    logic signed [15:0]     drive_reg [NUM_CHANNELS];
    logic signed [31:0]     cap_reg   [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] divp_reg;

    logic                   a_valid_reg;
    bcts_pkg::res_t         a_res_reg;

    logic [CH_W-1:0]        idx;
    bcts_pkg::item_t        it;
    bcts_pkg::phase_t       phase_cur;
    bcts_pkg::phase_t       phase_next;
    logic [15:0]            peak_next;
    logic signed [15:0]     drive_next;
    logic signed [31:0]     cap_next;
    logic                   divp_next;
    logic                   wiring;
    logic signed [16:0]     drop;
    logic                   full;
    logic signed [33:0]     diff;
    logic signed [31:0]     cap_sat;
    logic                   idle;

    assign it      = head.item;
    assign idx     = CH_W'(it.channel);
    assign pop     = head.valid && advance;
    assign a_valid = a_valid_reg;
    assign a_res   = a_res_reg;

    // full: above the full voltage, or dropped too far below the tracked peak
    assign drop = $signed({1'b0, peak_reg[idx]}) - $signed({1'b0, it.voltage});
    assign full = (it.voltage > cfg.full_v) || (drop > $signed({1'b0, cfg.peak_drop}));
    assign idle = it.current < cfg.idle_cur;

    // saturating mA-s integration
    assign diff = 34'(cap_reg[idx]) - 34'(it.avg_current);
    always_comb
    begin
        if (diff[33:31] == 3'b000 || diff[33:31] == 3'b111)
        begin
            cap_sat = diff[31:0];
        end
        else if (diff[33])
        begin
            cap_sat = 32'sh8000_0000;
        end
        else
        begin
            cap_sat = 32'sh7FFF_FFFF;
        end
    end

    always_comb
    begin
        phase_cur  = it.fault ? bcts_pkg::PH_ERROR : phase_reg[idx];
        phase_next = phase_cur;
        peak_next  = peak_reg[idx];
        drive_next = it.fault ? 16'sd0 : drive_reg[idx];
        cap_next   = cap_reg[idx];
        divp_next  = divp_reg[idx];
        wiring     = 1'b0;
        unique case (phase_cur)
            bcts_pkg::PH_ABSENT:
            begin
                if (it.voltage < cfg.fault_v)
                begin
                    wiring = 1'b1;
                end
                else if (it.voltage < cfg.absent_v)
                begin
                    cap_next   = '0;
                    divp_next  = 1'b0;
                    peak_next  = '0;
                    drive_next = '0;
                    phase_next = bcts_pkg::PH_SETUP;
                end
            end
            bcts_pkg::PH_SETUP:
            begin
                if (it.start)
                begin
                    peak_next  = '0;
                    drive_next = $signed({1'b0, cfg.chg_cur});
                    phase_next = bcts_pkg::PH_CHARGE;
                end
            end
            bcts_pkg::PH_CHARGE,
            bcts_pkg::PH_RECHARGE:
            begin
                if (full)
                begin
                    if (phase_cur == bcts_pkg::PH_CHARGE)
                    begin
                        drive_next = '0;
                        phase_next = bcts_pkg::PH_WAIT1;
                    end
                    else
                    begin
                        drive_next = bcts_pkg::TRICKLE_MA;
                        phase_next = bcts_pkg::PH_CHARGED;
                    end
                end
                else if (peak_reg[idx] < it.voltage)
                begin
                    peak_next = it.voltage;
                end
            end
            bcts_pkg::PH_WAIT1:
            begin
                if (idle)
                begin
                    cap_next   = '0;
                    divp_next  = 1'b0;
                    drive_next = -$signed({1'b0, cfg.dis_cur});
                    phase_next = bcts_pkg::PH_DISCHARGE;
                end
            end
            bcts_pkg::PH_DISCHARGE:
            begin
                cap_next = cap_sat;
                // the mAh conversion is applied on the way out
                if (it.voltage < cfg.empty_v || it.voltage > cfg.absent_v)
                begin
                    divp_next  = 1'b1;
                    drive_next = '0;
                    phase_next = bcts_pkg::PH_WAIT2;
                end
            end
            bcts_pkg::PH_WAIT2:
            begin
                if (idle)
                begin
                    drive_next = $signed({1'b0, cfg.chg_cur});
                    peak_next  = '0;
                    phase_next = bcts_pkg::PH_RECHARGE;
                end
            end
            bcts_pkg::PH_CHARGED:
            begin
                if (it.voltage > cfg.absent_v)
                begin
                    phase_next = bcts_pkg::PH_ABSENT;
                end
            end
            default:
            begin
                phase_next = phase_cur;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                phase_reg[i] <= bcts_pkg::PH_ABSENT;
                peak_reg[i]  <= '0;
                drive_reg[i] <= '0;
                cap_reg[i]   <= '0;
            end
            divp_reg    <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg[idx] <= phase_next;
                peak_reg[idx]  <= peak_next;
                drive_reg[idx] <= drive_next;
                cap_reg[idx]   <= cap_next;
                divp_reg[idx]  <= divp_next;
            end
            if (advance)
            begin
                a_valid_reg <= pop;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_res_reg.channel     <= it.channel;
            a_res_reg.phase       <= phase_next;
            a_res_reg.drive       <= drive_next;
            a_res_reg.cap         <= cap_next;
            a_res_reg.div_pending <= divp_next;
            a_res_reg.wiring      <= wiring;
        end
    end

endmodule

FILE: rtl/core/bcts_div.sv
// output pipeline: mA-s to mAh conversion by reciprocal multiply, result register
module bcts_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic                               a_valid,
    input  bcts_pkg::res_t                     a_res,
    output logic                               m_axis_tvalid,
    output logic [bcts_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [bcts_pkg::CH_FIELD_W-1:0]    m_axis_tuser
);

    localparam logic [bcts_pkg::RECIP_W-1:0] RECIP = bcts_pkg::RECIP_W'(bcts_pkg::RECIP_VAL);
    localparam logic [11:0] DIVISOR = 12'(bcts_pkg::SECONDS_PER_HOUR);

    logic                               b_valid_reg;
    bcts_pkg::res_t                     b_res_reg;
    logic [31:0]                        b_abs_reg;
    logic [bcts_pkg::PROD_W-1:0]        b_prod_reg;
    logic                               c_valid_reg;
    bcts_pkg::res_t                     c_res_reg;
    logic [bcts_pkg::QUOT_W-1:0]        c_qe_reg;
    logic [31:0]                        c_rem_reg;
    logic                               d_valid_reg;
    bcts_pkg::res_t                     d_res_reg;

    logic [31:0]                        abs_val;
    logic [bcts_pkg::QUOT_W-1:0]        qe;
    logic [bcts_pkg::QUOT_W-1:0]        q;
    logic signed [31:0]                 quot;
    logic signed [31:0]                 cap_out;
    bcts_pkg::res_t                     c_res_out;

    assign abs_val = a_res.cap[31] ? 32'(-a_res.cap) : 32'(a_res.cap);
    assign qe      = b_prod_reg[bcts_pkg::RECIP_SHIFT +: bcts_pkg::QUOT_W];

    // estimate is at most one low; one compare fixes it, then the sign goes back
    assign q       = c_qe_reg + bcts_pkg::QUOT_W'(c_rem_reg >= 32'(DIVISOR));
    assign quot    = c_res_reg.cap[31] ? -$signed(32'(q)) : $signed(32'(q));
    assign cap_out = c_res_reg.div_pending ? quot : c_res_reg.cap;

    always_comb
    begin
        c_res_out     = c_res_reg;
        c_res_out.cap = cap_out;
    end

    assign m_axis_tvalid = d_valid_reg;
    assign m_axis_tuser  = d_res_reg.channel;
    assign m_axis_tdata  = {3'b000, d_res_reg.wiring, d_res_reg.cap,
                            d_res_reg.drive, d_res_reg.phase};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_res_reg  <= a_res;
            b_abs_reg  <= abs_val;
            b_prod_reg <= abs_val * RECIP;
            c_res_reg  <= b_res_reg;
            c_qe_reg   <= qe;
            c_rem_reg  <= b_abs_reg - 32'(qe) * 32'(DIVISOR);
            d_res_reg  <= c_res_out;
        end
    end

endmodule

FILE: rtl/core/battery_capacity_test_sequencer_core.sv
// top level of the battery capacity test sequencer: config registers and block wiring

// One item is one one-second tick for one channel; it moves that channel through
// absent, setup, charge, wait, discharge, wait, recharge and charged, or into
// error on a sensor fault, and returns one result with the new phase, drive setpoint
// and capacity (mA-s during discharge, mAh after). The block takes one item per clock
// cycle while the output is not stalled; the per-channel state is read, updated and
// written back as the item is popped, so ticks for the same channel may follow each
// other directly. An item passes through the four-entry input queue, at whose pop the
// state update is registered, and then through the b, c and d registers of the divide
// by 3600, done with a reciprocal multiply and one correction step. Items for a channel
// at or above NUM_CHANNELS are accepted and dropped without a result. State is cleared
// directly by reset; there is no clearing pass. Configuration writes take effect at
// the next clock edge.
module battery_capacity_test_sequencer_core #(
    parameter int NUM_CHANNELS = bcts_pkg::NUM_CHANNELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // voltage_mv[15:0], current_ma[31:16], avg_current_ma[47:32],
    // start_request[48], sensor_fault[49], zero fill[55:50]
    input  logic [bcts_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // channel[1:0]
    input  logic [bcts_pkg::CH_FIELD_W-1:0]    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // phase[3:0], drive_current_ma[19:4], capacity[51:20], wiring_fault[52],
    // zero fill[55:53]
    output logic [bcts_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // result_channel[1:0]
    output logic [bcts_pkg::CH_FIELD_W-1:0]    m_axis_tuser,
    input  logic                               cfg_wr_en,
    input  logic [bcts_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bcts_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    bcts_pkg::cfg_t     cfg_reg;
    bcts_pkg::cfg_t     cfg_next;
    bcts_pkg::q_head_t  head;
    logic               pop;
    logic               advance;
    logic               a_valid;
    bcts_pkg::res_t     a_res;

    // the whole back pipeline moves unless a result is waiting
    assign advance = !m_axis_tvalid || m_axis_tready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (bcts_pkg::cfg_idx_t'(cfg_addr))
                bcts_pkg::CFG_FULL_V:    cfg_next.full_v    = cfg_wdata;
                bcts_pkg::CFG_PEAK_DROP: cfg_next.peak_drop = cfg_wdata;
                bcts_pkg::CFG_FAULT_V:   cfg_next.fault_v   = cfg_wdata;
                bcts_pkg::CFG_ABSENT_V:  cfg_next.absent_v  = cfg_wdata;
                bcts_pkg::CFG_IDLE_CUR:  cfg_next.idle_cur  = $signed(cfg_wdata);
                bcts_pkg::CFG_EMPTY_V:   cfg_next.empty_v   = cfg_wdata;
                bcts_pkg::CFG_CHG_CUR:   cfg_next.chg_cur   = cfg_wdata[14:0];
                bcts_pkg::CFG_DIS_CUR:   cfg_next.dis_cur   = cfg_wdata[14:0];
                default:                 cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_v    <= bcts_pkg::RST_FULL_V;
            cfg_reg.peak_drop <= bcts_pkg::RST_PEAK_DROP;
            cfg_reg.fault_v   <= bcts_pkg::RST_FAULT_V;
            cfg_reg.absent_v  <= bcts_pkg::RST_ABSENT_V;
            cfg_reg.idle_cur  <= $signed(bcts_pkg::RST_IDLE_CUR);
            cfg_reg.empty_v   <= bcts_pkg::RST_EMPTY_V;
            cfg_reg.chg_cur   <= bcts_pkg::RST_CHG_CUR;
            cfg_reg.dis_cur   <= bcts_pkg::RST_DIS_CUR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bcts_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .pop           (pop),
        .head          (head)
    );

    bcts_exec #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_exec (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .head    (head),
        .advance (advance),
        .pop     (pop),
        .a_valid (a_valid),
        .a_res   (a_res)
    );

    bcts_div u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .a_valid       (a_valid),
        .a_res         (a_res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef ASSERT_OFF
    // an item is only taken from the queue when one is there
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
        else $error("queue popped while empty");

    // a wiring fault is only reported for an absent channel
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[52]) |-> (m_axis_tdata[3:0] == bcts_pkg::PH_ABSENT))
        else $error("wiring fault outside absent phase");

    // sensor error always drives zero current
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[3:0] == bcts_pkg::PH_ERROR) |-> (m_axis_tdata[19:4] == '0))
        else $error("nonzero drive in sensor error");

    // a charged channel always trickles
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[3:0] == bcts_pkg::PH_CHARGED)
        |-> (m_axis_tdata[19:4] == bcts_pkg::TRICKLE_MA))
        else $error("charged channel not at trickle current");
`endif

endmodule
